/* src/nfc_response_frame_parser_unit_assert.svh */
// Assertion macros shared by the frame parser RTL.
`ifndef NFC_RESPONSE_FRAME_PARSER_UNIT_ASSERT_SVH
`define NFC_RESPONSE_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NFCRFP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame parser assertion failed");

// Next-cycle implication, checked outside reset.
`define NFCRFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame parser assertion failed");

`endif

/* src/nfcrfp_pkg.sv */
// Package: codes, configuration defaults and types of the frame parser.
package nfcrfp_pkg;

   // Phase codes of the receive sequencer
   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_LENGTH  = 3'd1;
   localparam logic [2:0] PH_IDENT   = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_TRAILER = 3'd4;

   // Final status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_NOSPACE = 2'd3;

   // Operation codes of an input word
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register map
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_COMMAND  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_FRAME_ID = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_CAPACITY   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS     = 8'd3;

   localparam logic [7:0]  RST_EXPECTED_COMMAND  = 8'd0;
   localparam logic [7:0]  RST_RESPONSE_FRAME_ID = 8'd213;
   localparam logic [7:0]  RST_BUFFER_CAPACITY   = 8'd255;
   localparam logic [15:0] RST_TIMEOUT_TICKS     = 16'd1000;

   localparam int TICK_COUNT_BITS_DEF = 16;

   localparam logic [7:0] START_LEAD = 8'h00;
   localparam logic [7:0] START_LAST = 8'hFF;
   localparam logic [7:0] POSTAMBLE  = 8'h00;

   typedef struct packed {
      logic [7:0]  expected_command;
      logic [7:0]  response_frame_id;
      logic [7:0]  buffer_capacity;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

/* src/nfcrfp_csr.sv */
// Configuration register block of the frame parser.
module nfcrfp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nfcrfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nfcrfp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output nfcrfp_pkg::cfg_type                cfg
);

   nfcrfp_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command  <= nfcrfp_pkg::RST_EXPECTED_COMMAND;
         cfg_ff.response_frame_id <= nfcrfp_pkg::RST_RESPONSE_FRAME_ID;
         cfg_ff.buffer_capacity   <= nfcrfp_pkg::RST_BUFFER_CAPACITY;
         cfg_ff.timeout_ticks     <= nfcrfp_pkg::RST_TIMEOUT_TICKS;
      end else if (csr_valid) begin
         // unknown indexes are ignored
         unique case (csr_index)
            nfcrfp_pkg::CSR_EXPECTED_COMMAND:  cfg_ff.expected_command  <= csr_wdata[7:0];
            nfcrfp_pkg::CSR_RESPONSE_FRAME_ID: cfg_ff.response_frame_id <= csr_wdata[7:0];
            nfcrfp_pkg::CSR_BUFFER_CAPACITY:   cfg_ff.buffer_capacity   <= csr_wdata[7:0];
            nfcrfp_pkg::CSR_TIMEOUT_TICKS:     cfg_ff.timeout_ticks     <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

/* src/nfc_response_frame_parser_unit.sv */
// A result word is registered: it appears in the cycle after the input word that causes it is accepted.
// Throughput: one input word (byte or tick) per cycle; input stalls only while
//   the output register holds a word that the sink is stalling.
// Reset (synchronous, active high): parser restarts at the start code, tick
//   counter cleared, registers to defaults; no clearing pass is needed.
`include "nfc_response_frame_parser_unit_assert.svh"

module nfc_response_frame_parser_unit #(
   parameter int TICK_COUNT_BITS = nfcrfp_pkg::TICK_COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [7:0]                         req_received_byte,
   // result words
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_payload_byte,
   output logic                               rsp_is_final,
   output logic [1:0]                         rsp_status,
   output logic [7:0]                         rsp_frame_length,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nfcrfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nfcrfp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Compare width wide enough for both the counter and the limit register
   localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
   localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = {TICK_COUNT_BITS{1'b1}};

   nfcrfp_pkg::cfg_type cfg;

   nfcrfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   logic [2:0]                 phase_ff,  phase_in;
   logic [1:0]                 idx_ff,    idx_in;     // byte position in chunk
   logic [7:0]                 length_ff, length_in;
   logic [7:0]                 left_ff,   left_in;    // payload bytes still due
   logic [7:0]                 total_ff,  total_in;
   logic [7:0]                 sum_ff,    sum_in;     // data checksum, mod 256
   logic [TICK_COUNT_BITS-1:0] tick_ff,   tick_in;
   logic                       bad_ff,    bad_in;     // earlier byte of chunk wrong

   // Result of the current word
   logic       res_valid;
   logic [7:0] res_byte;
   logic       res_final;
   logic [1:0] res_status;
   logic [7:0] res_length;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_final_ff;
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_length_ff;

   logic             accept;
   logic [7:0]       resp_code;
   logic [CMP_W-1:0] tick_cmp;
   logic [CMP_W-1:0] limit_cmp;
   logic [7:0]       pay_len;

   // A word may enter whenever the output register is free or draining.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign resp_code = cfg.expected_command + 8'd1;
   assign pay_len   = length_ff - 8'd2;

   always_comb begin
      // hold by default
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      total_in   = total_ff;
      sum_in     = sum_ff;
      tick_in    = tick_ff;
      bad_in     = bad_ff;
      res_valid  = 1'b0;
      res_byte   = 8'd0;
      res_final  = 1'b0;
      res_status = nfcrfp_pkg::ST_OK;
      res_length = 8'd0;
      tick_cmp   = '0;
      limit_cmp  = CMP_W'(cfg.timeout_ticks);

      if (req_operation == nfcrfp_pkg::OP_TICK) begin
         // saturating tick count, timeout once it reaches the limit
         if (tick_ff != TICK_MAX) begin
            tick_in = tick_ff + 1'b1;
         end
         tick_cmp = CMP_W'(tick_in);
         if (tick_cmp >= limit_cmp) begin
            res_valid  = 1'b1;
            res_final  = 1'b1;
            res_status = nfcrfp_pkg::ST_TIMEOUT;
         end
      end else begin
         unique case (phase_ff)
            nfcrfp_pkg::PH_START: begin
               if (idx_ff < 2'd2) begin
                  bad_in = bad_ff | (req_received_byte != nfcrfp_pkg::START_LEAD);
                  idx_in = idx_ff + 2'd1;
               end else begin
                  bad_in = bad_ff | (req_received_byte != nfcrfp_pkg::START_LAST);
                  if (bad_in) begin
                     res_valid  = 1'b1;
                     res_final  = 1'b1;
                     res_status = nfcrfp_pkg::ST_INVALID;
                  end else begin
                     phase_in = nfcrfp_pkg::PH_LENGTH;
                     idx_in   = 2'd0;
                     bad_in   = 1'b0;
                     tick_in  = '0;
                  end
               end
            end
            nfcrfp_pkg::PH_LENGTH: begin
               if (idx_ff == 2'd0) begin
                  length_in = req_received_byte;
                  idx_in    = 2'd1;
               end else if ((length_ff + req_received_byte) != 8'd0) begin
                  // checksum beats the capacity test
                  res_valid  = 1'b1;
                  res_final  = 1'b1;
                  res_status = nfcrfp_pkg::ST_INVALID;
               end else if (pay_len > cfg.buffer_capacity) begin
                  res_valid  = 1'b1;
                  res_final  = 1'b1;
                  res_status = nfcrfp_pkg::ST_NOSPACE;
               end else begin
                  total_in = pay_len;
                  left_in  = pay_len;
                  phase_in = nfcrfp_pkg::PH_IDENT;
                  idx_in   = 2'd0;
                  bad_in   = 1'b0;
                  tick_in  = '0;
               end
            end
            nfcrfp_pkg::PH_IDENT: begin
               if (idx_ff == 2'd0) begin
                  bad_in = bad_ff | (req_received_byte != cfg.response_frame_id);
                  idx_in = 2'd1;
               end else if (bad_ff || (req_received_byte != resp_code)) begin
                  res_valid  = 1'b1;
                  res_final  = 1'b1;
                  res_status = nfcrfp_pkg::ST_INVALID;
               end else begin
                  sum_in   = cfg.response_frame_id + resp_code;
                  // empty payload goes straight to the trailer
                  phase_in = (left_ff == 8'd0) ? nfcrfp_pkg::PH_TRAILER
                                               : nfcrfp_pkg::PH_PAYLOAD;
                  idx_in   = 2'd0;
                  bad_in   = 1'b0;
                  tick_in  = '0;
               end
            end
            nfcrfp_pkg::PH_PAYLOAD: begin
               sum_in    = sum_ff + req_received_byte;
               left_in   = left_ff - 8'd1;
               res_valid = 1'b1;
               res_byte  = req_received_byte;
               if (left_in == 8'd0) begin
                  phase_in = nfcrfp_pkg::PH_TRAILER;
                  idx_in   = 2'd0;
                  bad_in   = 1'b0;
                  tick_in  = '0;
               end
            end
            default: begin
               // trailer: checksum, then postamble
               if (idx_ff == 2'd0) begin
                  bad_in = bad_ff | ((sum_ff + req_received_byte) != 8'd0);
                  idx_in = 2'd1;
               end else begin
                  res_valid = 1'b1;
                  res_final = 1'b1;
                  if (bad_ff || (req_received_byte != nfcrfp_pkg::POSTAMBLE)) begin
                     res_status = nfcrfp_pkg::ST_INVALID;
                  end else begin
                     res_status = nfcrfp_pkg::ST_OK;
                     res_length = total_ff;
                  end
               end
            end
         endcase
      end

      // every final status restarts the parser
      if (res_final) begin
         phase_in  = nfcrfp_pkg::PH_START;
         idx_in    = 2'd0;
         length_in = 8'd0;
         left_in   = 8'd0;
         total_in  = 8'd0;
         sum_in    = 8'd0;
         tick_in   = '0;
         bad_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= nfcrfp_pkg::PH_START;
         idx_ff    <= 2'd0;
         length_ff <= 8'd0;
         left_ff   <= 8'd0;
         total_ff  <= 8'd0;
         sum_ff    <= 8'd0;
         tick_ff   <= '0;
         bad_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         total_ff  <= total_in;
         sum_ff    <= sum_in;
         tick_ff   <= tick_in;
         bad_ff    <= bad_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register: loads on accept, otherwise holds while stalled
   // ---------------------------------------------------------------
   assign rsp_valid_in = accept ? res_valid : (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_byte_ff   <= res_byte;
         rsp_final_ff  <= res_final;
         rsp_status_ff <= res_status;
         rsp_length_ff <= res_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_is_final     = rsp_final_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_length = rsp_length_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `NFCRFP_ASSERT_NOW(a_payload_word_clean, clock, reset, rsp_valid && !rsp_is_final, (rsp_status == nfcrfp_pkg::ST_OK) && (rsp_frame_length == 8'd0))
   `NFCRFP_ASSERT_NOW(a_error_no_length, clock, reset, rsp_valid && rsp_is_final && (rsp_status != nfcrfp_pkg::ST_OK), rsp_frame_length == 8'd0)
   `NFCRFP_ASSERT_NEXT(a_final_restarts, clock, reset, accept && res_final, (phase_ff == nfcrfp_pkg::PH_START) && (tick_ff == '0) && (idx_ff == 2'd0))
   `NFCRFP_ASSERT_NOW(a_payload_pending, clock, reset, phase_ff == nfcrfp_pkg::PH_PAYLOAD, left_ff != 8'd0)

endmodule

/* verif/nfc_response_frame_parser_unit_tb.sv */
// Self-checking testbench for the response frame parser: directed table, then random frames.
module nfc_response_frame_parser_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICK_BITS   = nfcrfp_pkg::TICK_COUNT_BITS_DEF;
   localparam int IDX_W       = nfcrfp_pkg::CSR_INDEX_W;
   localparam int DATA_W      = nfcrfp_pkg::CSR_DATA_W;
   localparam int SETTLE      = 4;       // result word is registered behind its word; a little margin
   localparam int HOLD_CYCLES = 300;     // long sink hold-off, enough to back the parser up
   localparam int CYCLE_LIMIT = 600000;  // watchdog limit for the whole run

   // One result word, fields in port order
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_final;
      logic [1:0] status;
      logic [7:0] frame_length;
   } frame_result_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_CSR} row_kind_type;

   // Directed row: a byte, a tick or a register write (index in data).
   // With typed set, the final status is written out here rather than predicted.
   typedef struct packed {
      row_kind_type     kind;
      logic [7:0]       data;
      logic [15:0]      wdata;
      logic             typed;
      frame_result_type res;
   } row_type;

   localparam frame_result_type NO_RESULT   = '0;
   localparam frame_result_type END_OK_0    = '{8'h00, 1'b1, nfcrfp_pkg::ST_OK,      8'h00};
   localparam frame_result_type END_INVALID = '{8'h00, 1'b1, nfcrfp_pkg::ST_INVALID, 8'h00};
   localparam frame_result_type END_NOSPACE = '{8'h00, 1'b1, nfcrfp_pkg::ST_NOSPACE, 8'h00};
   localparam frame_result_type END_TIMEOUT = '{8'h00, 1'b1, nfcrfp_pkg::ST_TIMEOUT, 8'h00};

   // ---------------------------------------------------------------- DUT ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = nfcrfp_pkg::OP_BYTE;
   logic [7:0]  req_received_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_is_final;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_frame_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   nfc_response_frame_parser_unit #(
      .TICK_COUNT_BITS(TICK_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_received_byte (req_received_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_is_final      (rsp_is_final),
      .rsp_status        (rsp_status),
      .rsp_frame_length  (rsp_frame_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- bookkeeping
   frame_result_type expected_results[$];   // oldest first
   int  mismatches = 0;
   int  words_sent = 0;
   int  payload_seen = 0;
   int  endings_seen[4] = '{0, 0, 0, 0};  // indexed by status code
   int  input_stall_cycles = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;               // main process only
   int  stall_pct = 0;                   // written by NBA, read by the sink process
   logic hold_ask = 1'b0;                // toggled by main to request a long hold-off
   logic hold_seen = 1'b0;
   int  hold_left = 0;

   // ---------------------------------------------------------------- parser mirror
   // Own copy of the register file and the receive sequencer.
   nfcrfp_pkg::cfg_type  model_cfg;
   logic [2:0]           rx_phase;
   logic [1:0]           rx_index;    // position inside the current chunk
   logic [7:0]           rx_len;      // LEN byte, held until LCS arrives
   logic [7:0]           rx_left;     // payload bytes still to come
   logic [7:0]           rx_total;    // payload length of this frame
   logic [7:0]           rx_sum;      // running data checksum
   logic [TICK_BITS-1:0] rx_ticks;    // ticks since the current chunk began
   logic                 rx_bad;      // a byte of this chunk was wrong

   function automatic void restart_parser();
      rx_phase = nfcrfp_pkg::PH_START;
      rx_index = '0;
      rx_len   = '0;
      rx_left  = '0;
      rx_total = '0;
      rx_sum   = '0;
      rx_ticks = '0;
      rx_bad   = 1'b0;
   endfunction

   function automatic void next_chunk(input logic [2:0] ph);
      rx_phase = ph;
      rx_index = '0;
      rx_bad   = 1'b0;
      rx_ticks = '0;
   endfunction

   function automatic frame_result_type frame_end(input logic [1:0] st,
                                                  input logic [7:0] flen);
      frame_result_type r;
      r = '0;
      r.is_final = 1'b1;
      r.status = st;
      r.frame_length = flen;
      restart_parser();
      return r;
   endfunction

   // Advance the mirror by one accepted word; returns 1 when a result word is due.
   function automatic bit parse_word(input logic op, input logic [7:0] b,
                                     output frame_result_type r);
      logic [7:0] resp;
      logic [7:0] acc;
      resp = model_cfg.expected_command + 8'd1;
      r = '0;
      if (op == nfcrfp_pkg::OP_TICK) begin
         if (rx_ticks != '1) rx_ticks = rx_ticks + 1'b1;   // saturates
         if (rx_ticks >= model_cfg.timeout_ticks) begin
            r = frame_end(nfcrfp_pkg::ST_TIMEOUT, 8'd0);
            return 1'b1;
         end
         return 1'b0;
      end
      case (rx_phase)
         nfcrfp_pkg::PH_START: begin
            if (b != ((rx_index < 2'd2) ? nfcrfp_pkg::START_LEAD : nfcrfp_pkg::START_LAST))
               rx_bad = 1'b1;
            if (rx_index < 2'd2) begin
               rx_index = rx_index + 2'd1;
               return 1'b0;
            end
            if (rx_bad) begin
               r = frame_end(nfcrfp_pkg::ST_INVALID, 8'd0);
               return 1'b1;
            end
            next_chunk(nfcrfp_pkg::PH_LENGTH);
            return 1'b0;
         end
         nfcrfp_pkg::PH_LENGTH: begin
            if (rx_index == 2'd0) begin
               rx_len = b;
               rx_index = 2'd1;
               return 1'b0;
            end
            acc = rx_len + b;
            // checksum is judged before capacity
            if (acc != 8'd0) begin
               r = frame_end(nfcrfp_pkg::ST_INVALID, 8'd0);
               return 1'b1;
            end
            rx_total = rx_len - 8'd2;
            if (rx_total > model_cfg.buffer_capacity) begin
               r = frame_end(nfcrfp_pkg::ST_NOSPACE, 8'd0);
               return 1'b1;
            end
            rx_left = rx_total;
            next_chunk(nfcrfp_pkg::PH_IDENT);
            return 1'b0;
         end
         nfcrfp_pkg::PH_IDENT: begin
            if (rx_index == 2'd0) begin
               if (b != model_cfg.response_frame_id) rx_bad = 1'b1;
               rx_index = 2'd1;
               return 1'b0;
            end
            if (rx_bad || b != resp) begin
               r = frame_end(nfcrfp_pkg::ST_INVALID, 8'd0);
               return 1'b1;
            end
            rx_sum = model_cfg.response_frame_id + resp;
            next_chunk((rx_left == 8'd0) ? nfcrfp_pkg::PH_TRAILER : nfcrfp_pkg::PH_PAYLOAD);
            return 1'b0;
         end
         nfcrfp_pkg::PH_PAYLOAD: begin
            rx_sum = rx_sum + b;
            rx_left = rx_left - 8'd1;
            if (rx_left == 8'd0) next_chunk(nfcrfp_pkg::PH_TRAILER);
            r.payload_byte = b;
            return 1'b1;
         end
         default: begin
            if (rx_index == 2'd0) begin
               acc = rx_sum + b;
               if (acc != 8'd0) rx_bad = 1'b1;
               rx_index = 2'd1;
               return 1'b0;
            end
            if (rx_bad || b != nfcrfp_pkg::POSTAMBLE) begin
               r = frame_end(nfcrfp_pkg::ST_INVALID, 8'd0);
               return 1'b1;
            end
            r = frame_end(nfcrfp_pkg::ST_OK, rx_total);
            return 1'b1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- input side
   // Offer one word, after a random idle gap, and hold it until taken.
   task automatic send_word(input logic op, input logic [7:0] b,
                            input logic typed, input frame_result_type typed_res);
      int gap;
      frame_result_type r;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_received_byte <= b;
      do @(posedge clock); while (req_stall);
      // word taken at this edge
      words_sent++;
      if (parse_word(op, b, r) && !typed) expected_results.push_back(r);
      if (typed) expected_results.push_back(typed_res);
   endtask

   // Stop offering and wait until every predicted word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Register write, only ever with the parser quiet.
   task automatic idle_write(input logic [IDX_W-1:0] idx, input logic [15:0] value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);   // a lone byte may still be in flight
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         nfcrfp_pkg::CSR_EXPECTED_COMMAND:  model_cfg.expected_command  = value[7:0];
         nfcrfp_pkg::CSR_RESPONSE_FRAME_ID: model_cfg.response_frame_id = value[7:0];
         nfcrfp_pkg::CSR_BUFFER_CAPACITY:   model_cfg.buffer_capacity   = value[7:0];
         nfcrfp_pkg::CSR_TIMEOUT_TICKS:     model_cfg.timeout_ticks     = value;
         default: ;             // unmapped index: ignored
      endcase
   endtask

   // One frame with random content under the current registers; now and then
   // oversized, corrupted, or just stray words. forced_len >= 0 sends a clean
   // frame of that payload length.
   task automatic send_frame(input int tick_pct, input int forced_len);
      logic [7:0] fbytes[$];
      logic [7:0] resp;
      logic [7:0] sum;
      logic [7:0] lenb;
      logic [7:0] d;
      int pick;
      int cap;
      int plen;
      int pos;
      pick = $urandom_range(99);
      cap = model_cfg.buffer_capacity;
      if (forced_len < 0 && pick < 10) begin
         // noise between frames: stray bytes and ticks
         repeat ($urandom_range(6, 1))
            send_word(($urandom_range(99) < 40) ? nfcrfp_pkg::OP_TICK : nfcrfp_pkg::OP_BYTE,
                      8'($urandom), 1'b0, NO_RESULT);
         return;
      end
      if (forced_len >= 0)
         plen = forced_len;
      else if (pick < 22 && cap < 255)
         plen = $urandom_range(255, cap + 1);      // will not fit: no space
      else
         plen = $urandom_range((cap < 6) ? cap : 6, 0);
      resp = model_cfg.expected_command + 8'd1;
      lenb = 8'(plen + 2);
      fbytes = '{nfcrfp_pkg::START_LEAD, nfcrfp_pkg::START_LEAD, nfcrfp_pkg::START_LAST};
      fbytes.push_back(lenb);
      fbytes.push_back(8'd0 - lenb);
      if (plen <= cap) begin
         fbytes.push_back(model_cfg.response_frame_id);
         fbytes.push_back(resp);
         sum = model_cfg.response_frame_id + resp;
         for (int i = 0; i < plen; i++) begin
            d = 8'($urandom);
            fbytes.push_back(d);
            sum = sum + d;
         end
         fbytes.push_back(8'd0 - sum);
         fbytes.push_back(nfcrfp_pkg::POSTAMBLE);
      end
      if (forced_len < 0 && $urandom_range(99) < 15) begin
         pos = $urandom_range(fbytes.size() - 1, 0);
         fbytes[pos] = fbytes[pos] ^ 8'($urandom_range(255, 1));
      end
      foreach (fbytes[i]) begin
         if ($urandom_range(99) < tick_pct)
            send_word(nfcrfp_pkg::OP_TICK, 8'($urandom), 1'b0, NO_RESULT);
         send_word(nfcrfp_pkg::OP_BYTE, fbytes[i], 1'b0, NO_RESULT);
      end
   endtask

   // Program a setting, then stream random frames under the given idling.
   // Half-way the sender pauses for a full drain; with squeeze set the sink
   // also holds off for a long stretch while words keep coming.
   task automatic run_phase(input nfcrfp_pkg::cfg_type c, input int send_pct,
                            input int recv_pct, input int tick_pct, input bit squeeze,
                            input int budget);
      int first;
      bit paused;
      bit held;
      // 8-bit registers get junk in the upper byte, which must be dropped
      idle_write(nfcrfp_pkg::CSR_EXPECTED_COMMAND,  {8'($urandom), c.expected_command});
      idle_write(nfcrfp_pkg::CSR_RESPONSE_FRAME_ID, {8'($urandom), c.response_frame_id});
      idle_write(nfcrfp_pkg::CSR_BUFFER_CAPACITY,   {8'($urandom), c.buffer_capacity});
      idle_write(nfcrfp_pkg::CSR_TIMEOUT_TICKS,     c.timeout_ticks);
      idle_write(IDX_W'($urandom_range(255, 4)), 16'($urandom));
      send_idle_pct = send_pct;
      stall_pct <= recv_pct;
      first = words_sent;
      paused = 1'b0;
      held = 1'b0;
      while (words_sent - first < budget) begin
         if (squeeze && !held && words_sent - first >= budget / 4) begin
            hold_ask <= ~hold_ask;
            held = 1'b1;
         end
         if (!paused && words_sent - first >= budget / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         send_frame(tick_pct, -1);
      end
   endtask

   // ---------------------------------------------------------------- output side
   // Sink stall: random per cycle, or solid during a requested hold-off.
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic note_mismatch(input string what, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   // Result checker: every word taken from the parser against the oldest expectation.
   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_payload_byte, rsp_is_final, rsp_status, rsp_frame_length};
            if (expected_results.size() == 0) begin
               $display("%0t: result word mismatch, expected none, got %h", $time, got);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.payload_byte !== want.payload_byte)
                  note_mismatch("payload_byte", want.payload_byte, got.payload_byte);
               if (got.is_final !== want.is_final)
                  note_mismatch("is_final", want.is_final, got.is_final);
               if (got.status !== want.status)
                  note_mismatch("status", want.status, got.status);
               if (got.frame_length !== want.frame_length)
                  note_mismatch("frame_length", want.frame_length, got.frame_length);
               if (want.is_final) endings_seen[want.status]++;
               else payload_seen++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: cycle limit reached, %0d words still expected",
               $time, expected_results.size());
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus
   row_type             directed_rows[26];
   nfcrfp_pkg::cfg_type mixed_cfg;

   initial begin : stimulus
      directed_rows = '{
         // a tick under the default timeout: nothing happens
         '{ROW_TICK, 8'h5A, 16'h0000, 1'b0, NO_RESULT},
         // shortest good frame, empty payload, default registers
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hFF, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h02, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hFE, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hD5, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h01, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h2A, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b1, END_OK_0},
         // zero capacity: one payload byte no longer fits
         '{ROW_CSR,  nfcrfp_pkg::CSR_BUFFER_CAPACITY, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hFF, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h03, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hFD, 16'h0000, 1'b1, END_NOSPACE},
         // bad length checksum wins over the capacity test
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hFF, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h03, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b1, END_INVALID},
         // wrong first start byte: judged only when the chunk is complete
         '{ROW_BYTE, 8'h01, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'h00, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_BYTE, 8'hFF, 16'h0000, 1'b1, END_INVALID},
         // zero timeout: the very first tick ends the frame
         '{ROW_CSR,  nfcrfp_pkg::CSR_TIMEOUT_TICKS, 16'h0000, 1'b0, NO_RESULT},
         '{ROW_TICK, 8'hA5, 16'h0000, 1'b1, END_TIMEOUT}
      };

      model_cfg = '{nfcrfp_pkg::RST_EXPECTED_COMMAND, nfcrfp_pkg::RST_RESPONSE_FRAME_ID,
                    nfcrfp_pkg::RST_BUFFER_CAPACITY, nfcrfp_pkg::RST_TIMEOUT_TICKS};
      restart_parser();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CSR:  idle_write(directed_rows[i].data, directed_rows[i].wdata);
            ROW_TICK: send_word(nfcrfp_pkg::OP_TICK, directed_rows[i].data,
                                directed_rows[i].typed, directed_rows[i].res);
            default:  send_word(nfcrfp_pkg::OP_BYTE, directed_rows[i].data,
                                directed_rows[i].typed, directed_rows[i].res);
         endcase
      end

      // Random phases, one register setting each; extremes spread across them.
      // No idling at all
      run_phase('{8'h00, 8'hD5, 8'hFF, 16'd1000}, 0, 0, 3, 1'b0, 70);
      // Sender mostly idle; zero capacity, a single tick times out
      run_phase('{8'hFF, 8'h00, 8'h00, 16'd1}, 74, 0, 5, 1'b0, 70);
      // Sink mostly stalling; short timeout against frequent ticks
      run_phase('{8'h7F, 8'hFF, 8'd8, 16'd3}, 0, 74, 10, 1'b0, 70);
      // Light idling both sides, plus the long sink hold-off
      run_phase('{8'h4A, 8'hD4, 8'd20, 16'hFFFF}, 8, 8, 4, 1'b1, 70);
      // Random registers
      mixed_cfg.expected_command  = 8'($urandom);
      mixed_cfg.response_frame_id = 8'($urandom);
      mixed_cfg.buffer_capacity   = 8'($urandom);
      mixed_cfg.timeout_ticks     = 16'($urandom_range(40, 2));
      run_phase(mixed_cfg, 8, 8, 6, 1'b0, 70);
      // Full-size frame: LEN wraps to 01
      run_phase('{8'h03, 8'hD5, 8'hFF, 16'hFFFF}, 0, 0, 0, 1'b0, 0);
      send_frame(0, 255);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("summary: %0d words sent, %0d payload bytes checked, %0d cycles with input held",
               words_sent, payload_seen, input_stall_cycles);
      $display("summary: frame endings ok %0d, timeout %0d, invalid %0d, no space %0d",
               endings_seen[nfcrfp_pkg::ST_OK], endings_seen[nfcrfp_pkg::ST_TIMEOUT],
               endings_seen[nfcrfp_pkg::ST_INVALID], endings_seen[nfcrfp_pkg::ST_NOSPACE]);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
